### sv/mxd_pkg.sv
// ----------------------------------------------------------------------------
// mxd_pkg
// Shared types and fixed-point constants for the mixer / iir4 / dac drive.
// ----------------------------------------------------------------------------
package mxd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DAC_BITS    = 12;
  localparam int FRAC_BITS   = 20;

  localparam int COEF_W   = 24;
  localparam int OFF_W    = 22;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 3;
  localparam int NUM_GAIN = 7;
  localparam int X_W      = 26;
  localparam int Y_W      = 48;

  // sample to volts: floor(raw * 33 * 2^FRAC_BITS / (10 * (2^SAMPLE_BITS - 1)))
  localparam longint SAMPLE_FULL = (64'd1 << SAMPLE_BITS) - 1;
  localparam longint VOLT_DEN    = 10 * SAMPLE_FULL;
  localparam longint VOLT_NUM    = 64'd33 << FRAC_BITS;
  localparam longint VOLT_INT    = VOLT_NUM / VOLT_DEN;
  localparam longint VOLT_REM    = VOLT_NUM % VOLT_DEN;
  localparam int     VOLT_SH     = 37;
  localparam longint VOLT_RECIP  = ((64'd1 << VOLT_SH) + VOLT_DEN - 1) / VOLT_DEN;
  localparam int     VOLT_W      = 22;
  localparam int     VREM_W      = 21;
  localparam int     VRECIP_W    = 22;
  localparam int     VQP_W       = VREM_W + VRECIP_W;
  localparam int     DIFF_W      = VOLT_W + 1;
  localparam int     MIX_W       = 2 * DIFF_W;

  // volts to code: floor(s * 10 * 2^DAC_BITS / (33 * 2^FRAC_BITS)) for s < 8 V
  localparam int     DAC_IN_W    = FRAC_BITS + 3;
  localparam longint DAC_NUM     = 64'd10 << DAC_BITS;
  localparam longint DAC_DEN     = 64'd33 << FRAC_BITS;
  localparam int     DAC_SH      = 36;
  localparam longint DAC_RECIP   = (((64'd1 << DAC_SH) * DAC_NUM) + DAC_DEN - 1) / DAC_DEN;
  localparam int     DRECIP_W    = 27;
  localparam int     CPROD_W     = DAC_IN_W + DRECIP_W;
  localparam int     CODE_W      = CPROD_W - DAC_SH;
  localparam int     DAC_MAX     = (1 << DAC_BITS) - 1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [X_W-1:0]    x_t;

  typedef enum logic [IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B2     = 3'd1,
    REG_B4     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_A3     = 3'd5,
    REG_A4     = 3'd6,
    REG_OFFSET = 3'd7
  } reg_idx_t;

  localparam coef_t RST_B0 = 24'sd1049;
  localparam coef_t RST_B2 = -24'sd2097;
  localparam coef_t RST_B4 = 24'sd1049;
  localparam coef_t RST_A1 = 24'sd3319792;
  localparam coef_t RST_A2 = -24'sd4632609;
  localparam coef_t RST_A3 = 24'sd3175088;
  localparam coef_t RST_A4 = -24'sd959447;
  localparam logic [OFF_W-1:0] RST_OFFSET = 22'd1048576;

  typedef struct packed {
    coef_t [NUM_GAIN-1:0] gain;
    logic  [OFF_W-1:0]    offset;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
  } in_word_t;

  typedef struct packed {
    logic [DAC_BITS-1:0] dac_code;
    logic                clipped;
  } out_word_t;

endpackage

### sv/mxd_front.sv
// ----------------------------------------------------------------------------
// mxd_front
// Input pipeline: samples to volts, offset removal and mixing product.
// ----------------------------------------------------------------------------
module mxd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  mxd_pkg::in_word_t        in_word,
  input  logic [mxd_pkg::OFF_W-1:0] offset,
  output logic                     push,
  output mxd_pkg::x_t              push_x,
  input  logic                     q_full
);
  import mxd_pkg::*;

  logic adv;

  logic s1_v_r, s2_v_r, s3_v_r;

  logic [VOLT_W-1:0] base_a_r, base_b_r;
  logic [VREM_W-1:0] rem_a_r, rem_b_r;

  logic signed [DIFF_W-1:0] diff_a_r, diff_b_r;
  logic signed [MIX_W-1:0]  mix_r;

  logic [VQP_W-1:0]         quo_a_full, quo_b_full;
  logic [VOLT_W-1:0]        volts_a, volts_b;
  logic signed [DIFF_W-1:0] diff_a_nxt, diff_b_nxt;
  logic signed [MIX_W-1:0]  mix_nxt;

  assign adv      = !s3_v_r || !q_full;
  assign in_stall = !adv;
  assign push     = s3_v_r && !q_full;
  assign push_x   = mix_r[MIX_W-1:FRAC_BITS];

  always_comb begin
    quo_a_full = VQP_W'(rem_a_r) * VQP_W'(VOLT_RECIP);
    quo_b_full = VQP_W'(rem_b_r) * VQP_W'(VOLT_RECIP);
    volts_a    = base_a_r + VOLT_W'(quo_a_full[VQP_W-1:VOLT_SH]);
    volts_b    = base_b_r + VOLT_W'(quo_b_full[VQP_W-1:VOLT_SH]);
    diff_a_nxt = $signed({1'b0, volts_a}) - $signed({{(DIFF_W-OFF_W){1'b0}}, offset});
    diff_b_nxt = $signed({1'b0, volts_b}) - $signed({{(DIFF_W-OFF_W){1'b0}}, offset});
    mix_nxt    = diff_a_r * diff_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      base_a_r <= VOLT_W'(in_word.sample_a * VOLT_INT);
      base_b_r <= VOLT_W'(in_word.sample_b * VOLT_INT);
      rem_a_r  <= VREM_W'(in_word.sample_a * VOLT_REM);
      rem_b_r  <= VREM_W'(in_word.sample_b * VOLT_REM);
      diff_a_r <= diff_a_nxt;
      diff_b_r <= diff_b_nxt;
      mix_r    <= mix_nxt;
    end
  end

endmodule

### sv/mxd_fifo.sv
// ----------------------------------------------------------------------------
// mxd_fifo
// Two-entry queue of mixed products between front and filter engine.
// ----------------------------------------------------------------------------
module mxd_fifo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mxd_pkg::x_t push_x,
  output logic        full,
  input  logic        pop,
  output mxd_pkg::x_t pop_x,
  output logic        avail
);
  import mxd_pkg::*;

  x_t         mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign avail = (count_r != 2'd0);
  assign pop_x = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_x;
  end

endmodule

### sv/mxd_back.sv
// ----------------------------------------------------------------------------
// mxd_back
// Filter engine: shared multiply-accumulate over eleven terms, output
// saturation, volts to dac code conversion and output register.
// ----------------------------------------------------------------------------
module mxd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mxd_pkg::cfg_t      cfg,
  input  logic               q_avail,
  input  mxd_pkg::x_t        q_x,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mxd_pkg::out_word_t out_word
);
  import mxd_pkg::*;

  localparam int OP_W   = Y_W - FRAC_BITS;
  localparam int MUL_W  = COEF_W + OP_W;
  localparam int ACC_W  = MUL_W + 2;
  localparam int TOT_W  = ACC_W + 1;
  localparam int S_W    = Y_W + 1;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_MAC   = 6'b000010,
    B_DRAIN = 6'b000100,
    B_SUM   = 6'b001000,
    B_CONV  = 6'b010000,
    B_FIN   = 6'b100000
  } back_state_t;

  typedef enum logic [3:0] {
    ST_B0  = 4'd0,
    ST_B2  = 4'd1,
    ST_B4  = 4'd2,
    ST_A1H = 4'd3,
    ST_A2H = 4'd4,
    ST_A3H = 4'd5,
    ST_A4H = 4'd6,
    ST_A1L = 4'd7,
    ST_A2L = 4'd8,
    ST_A3L = 4'd9,
    ST_A4L = 4'd10
  } mac_step_t;

  back_state_t state_r, state_nxt;
  mac_step_t   step_r;

  x_t                    x_r;
  x_t                    ph_r [4];
  logic signed [Y_W-1:0] oh_r [4];

  logic signed [MUL_W-1:0] prod_r;
  logic                    prod_v_r, prod_hi_r;
  logic signed [ACC_W-1:0] hi_acc_r, lo_acc_r;
  logic signed [Y_W-1:0]   y_r;
  logic [CPROD_W-1:0]      cprod_r;
  logic                    neg_r, over_r;

  logic                    out_valid_r;
  out_word_t               out_word_r;

  coef_t                   mul_c;
  logic signed [OP_W-1:0]  mul_op;
  logic                    mul_hi;
  logic signed [MUL_W-1:0] prod_nxt;

  logic signed [ACC_W-1:0] lo_shift;
  logic signed [TOT_W-1:0] total;
  logic signed [Y_W-1:0]   y_nxt;

  logic signed [S_W-1:0]   drive;
  logic [CPROD_W-1:0]      cprod_nxt;
  logic [CODE_W-1:0]       code_full;
  out_word_t               out_nxt;
  logic                    load;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign pop       = (state_r == B_IDLE) && q_avail;
  assign load      = (state_r == B_FIN) && (!out_valid_r || !out_stall);

  // operand select for the shared multiplier
  always_comb begin
    mul_c  = '0;
    mul_op = '0;
    mul_hi = 1'b0;
    case (step_r)
      ST_B0: begin
        mul_c  = cfg.gain[REG_B0];
        mul_op = {{(OP_W-X_W){x_r[X_W-1]}}, x_r};
      end
      ST_B2: begin
        mul_c  = cfg.gain[REG_B2];
        mul_op = {{(OP_W-X_W){ph_r[1][X_W-1]}}, ph_r[1]};
      end
      ST_B4: begin
        mul_c  = cfg.gain[REG_B4];
        mul_op = {{(OP_W-X_W){ph_r[3][X_W-1]}}, ph_r[3]};
      end
      ST_A1H: begin
        mul_c  = cfg.gain[REG_A1];
        mul_op = oh_r[0][Y_W-1:FRAC_BITS];
        mul_hi = 1'b1;
      end
      ST_A2H: begin
        mul_c  = cfg.gain[REG_A2];
        mul_op = oh_r[1][Y_W-1:FRAC_BITS];
        mul_hi = 1'b1;
      end
      ST_A3H: begin
        mul_c  = cfg.gain[REG_A3];
        mul_op = oh_r[2][Y_W-1:FRAC_BITS];
        mul_hi = 1'b1;
      end
      ST_A4H: begin
        mul_c  = cfg.gain[REG_A4];
        mul_op = oh_r[3][Y_W-1:FRAC_BITS];
        mul_hi = 1'b1;
      end
      ST_A1L: begin
        mul_c  = cfg.gain[REG_A1];
        mul_op = {{(OP_W-FRAC_BITS){1'b0}}, oh_r[0][FRAC_BITS-1:0]};
      end
      ST_A2L: begin
        mul_c  = cfg.gain[REG_A2];
        mul_op = {{(OP_W-FRAC_BITS){1'b0}}, oh_r[1][FRAC_BITS-1:0]};
      end
      ST_A3L: begin
        mul_c  = cfg.gain[REG_A3];
        mul_op = {{(OP_W-FRAC_BITS){1'b0}}, oh_r[2][FRAC_BITS-1:0]};
      end
      ST_A4L: begin
        mul_c  = cfg.gain[REG_A4];
        mul_op = {{(OP_W-FRAC_BITS){1'b0}}, oh_r[3][FRAC_BITS-1:0]};
      end
      default: begin
        mul_c  = '0;
        mul_op = '0;
        mul_hi = 1'b0;
      end
    endcase
    prod_nxt = mul_c * mul_op;
  end

  // fold the two sums, floor shift and saturate
  always_comb begin
    lo_shift = lo_acc_r >>> FRAC_BITS;
    total    = $signed({hi_acc_r[ACC_W-1], hi_acc_r}) + $signed({lo_shift[ACC_W-1], lo_shift});
    if (total[TOT_W-1] && !(&total[TOT_W-2:Y_W-1])) begin
      y_nxt = {1'b1, {(Y_W-1){1'b0}}};
    end else if (!total[TOT_W-1] && (|total[TOT_W-2:Y_W-1])) begin
      y_nxt = {1'b0, {(Y_W-1){1'b1}}};
    end else begin
      y_nxt = total[Y_W-1:0];
    end
  end

  // dac code
  always_comb begin
    drive     = $signed({y_r[Y_W-1], y_r}) + $signed({{(S_W-OFF_W){1'b0}}, cfg.offset});
    cprod_nxt = CPROD_W'(drive[DAC_IN_W-1:0]) * CPROD_W'(DAC_RECIP);
    code_full = cprod_r[CPROD_W-1:DAC_SH];
    if (neg_r) begin
      out_nxt.dac_code = '0;
      out_nxt.clipped  = 1'b1;
    end else if (over_r || (code_full > CODE_W'(DAC_MAX))) begin
      out_nxt.dac_code = DAC_BITS'(DAC_MAX);
      out_nxt.clipped  = 1'b1;
    end else begin
      out_nxt.dac_code = code_full[DAC_BITS-1:0];
      out_nxt.clipped  = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (q_avail) state_nxt = B_MAC;
      B_MAC:   if (step_r == ST_A4L) state_nxt = B_DRAIN;
      B_DRAIN: state_nxt = B_SUM;
      B_SUM:   state_nxt = B_CONV;
      B_CONV:  state_nxt = B_FIN;
      B_FIN:   if (load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= ST_B0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        ph_r[i] <= '0;
        oh_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == B_MAC) begin
        step_r   <= mac_step_t'(step_r + 4'd1);
        prod_v_r <= 1'b1;
      end else begin
        step_r   <= ST_B0;
        prod_v_r <= 1'b0;
      end
      if (state_r == B_SUM) begin
        for (int i = 3; i > 0; i--) begin
          ph_r[i] <= ph_r[i-1];
          oh_r[i] <= oh_r[i-1];
        end
        ph_r[0] <= x_r;
        oh_r[0] <= y_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r      <= q_x;
      hi_acc_r <= '0;
      lo_acc_r <= '0;
    end else if (prod_v_r) begin
      if (prod_hi_r) begin
        hi_acc_r <= hi_acc_r + $signed({{(ACC_W-MUL_W){prod_r[MUL_W-1]}}, prod_r});
      end else begin
        lo_acc_r <= lo_acc_r + $signed({{(ACC_W-MUL_W){prod_r[MUL_W-1]}}, prod_r});
      end
    end
    prod_r    <= prod_nxt;
    prod_hi_r <= mul_hi;
    if (state_r == B_SUM) y_r <= y_nxt;
    if (state_r == B_CONV) begin
      cprod_r <= cprod_nxt;
      neg_r   <= drive[S_W-1];
      over_r  <= !drive[S_W-1] && (|drive[S_W-2:DAC_IN_W]);
    end
    if (load) out_word_r <= out_nxt;
  end

endmodule

### sv/mixer_iir4_dac_drive.sv
// ----------------------------------------------------------------------------
// mixer_iir4_dac_drive
// Mixes two converter samples, runs a fourth-order direct-form-I filter
// and drives a dac code with saturation.
//
//   channel | direction | handshake         | word
//   in_     | input     | in_valid/in_stall | in_word (sample_a, sample_b)
//   out_    | output    | out_valid/out_stall | out_word (dac_code, clipped)
//   cfg_    | input     | cfg_we            | cfg_index, cfg_data
//
// The filter engine takes one word at a time: it pops the queue, forms
// eleven products on its single shared multiplier, then drains, sums,
// converts and loads. A 2-word queue sits between it and the front pipeline.
// Reset is synchronous, active low; config registers return to defaults.
// A stalled output word holds; the engine waits in its load step until taken.
// ----------------------------------------------------------------------------
module mixer_iir4_dac_drive (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mxd_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mxd_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic [mxd_pkg::IDX_W-1:0] cfg_index,
  input  logic [mxd_pkg::CFG_W-1:0] cfg_data
);
  import mxd_pkg::*;

  cfg_t regs_r;
  logic push, q_full, pop, q_avail;
  x_t   push_x, pop_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.gain[REG_B0] <= RST_B0;
      regs_r.gain[REG_B2] <= RST_B2;
      regs_r.gain[REG_B4] <= RST_B4;
      regs_r.gain[REG_A1] <= RST_A1;
      regs_r.gain[REG_A2] <= RST_A2;
      regs_r.gain[REG_A3] <= RST_A3;
      regs_r.gain[REG_A4] <= RST_A4;
      regs_r.offset       <= RST_OFFSET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_OFFSET: regs_r.offset <= cfg_data[OFF_W-1:0];
        default:    regs_r.gain[cfg_index] <= cfg_data[COEF_W-1:0];
      endcase
    end
  end

  mxd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .offset   (regs_r.offset),
    .push     (push),
    .push_x   (push_x),
    .q_full   (q_full)
  );

  mxd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .push_x (push_x),
    .full   (q_full),
    .pop    (pop),
    .pop_x  (pop_x),
    .avail  (q_avail)
  );

  mxd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (regs_r),
    .q_avail   (q_avail),
    .q_x       (pop_x),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
